// File: rtl/core/aaup_pkg.sv
// types, constants and helper functions shared by the alarm annunciator
`timescale 1ns / 1ps
package aaup_pkg;

  localparam int IDX_W  = 9;
  localparam int FLAG_W = 16;
  localparam int WORD_W = 12;
  localparam int TIME_W = 32;
  localparam int LVL_W  = 3;

  // single alarm bits
  localparam logic [WORD_W-1:0] BIT_BRK_LO = 12'h008;
  localparam logic [WORD_W-1:0] BIT_BRK_HI = 12'h800;
  localparam logic [WORD_W-1:0] BIT_L3_LO  = 12'h004;
  localparam logic [WORD_W-1:0] BIT_L3_HI  = 12'h400;
  localparam logic [WORD_W-1:0] BIT_L2_LO  = 12'h002;
  localparam logic [WORD_W-1:0] BIT_L2_HI  = 12'h200;
  localparam logic [WORD_W-1:0] BIT_L1_LO  = 12'h001;
  localparam logic [WORD_W-1:0] BIT_L1_HI  = 12'h100;
  localparam logic [WORD_W-1:0] BIT_NONE   = 12'h000;

  // level masks over both bytes
  localparam logic [WORD_W-1:0] MASK_BRK  = 12'h808;
  localparam logic [WORD_W-1:0] MASK_L3   = 12'h404;
  localparam logic [WORD_W-1:0] MASK_L2   = 12'h202;
  localparam logic [WORD_W-1:0] MASK_L1   = 12'h101;
  localparam logic [WORD_W-1:0] MASK_HELD = 12'h606;

  localparam logic [WORD_W-1:0] FLASH_BIT     = 12'h010;
  localparam logic [WORD_W-1:0] CLR_FLASH     = 12'hfef;
  localparam logic [WORD_W-1:0] CLR_BRK_LO    = 12'hff7;

  // level codes
  localparam logic [WORD_W-1:0] CODE_BRK  = 12'h008;
  localparam logic [WORD_W-1:0] CODE_L3   = 12'h004;
  localparam logic [WORD_W-1:0] CODE_L2   = 12'h002;
  localparam logic [WORD_W-1:0] CODE_L1   = 12'h001;
  localparam logic [WORD_W-1:0] CODE_NORM = 12'h000;

  // shown level numbers
  localparam logic [LVL_W-1:0] SHOWN_NORM = 3'd0;
  localparam logic [LVL_W-1:0] SHOWN_L1   = 3'd1;
  localparam logic [LVL_W-1:0] SHOWN_L2   = 3'd2;
  localparam logic [LVL_W-1:0] SHOWN_L3   = 3'd3;
  localparam logic [LVL_W-1:0] SHOWN_BRK  = 3'd4;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } aaup_state_t;

  typedef struct packed {
    logic              wr;
    logic [WORD_W-1:0] word;
    logic [TIME_W-1:0] tstamp;
  } aaup_upd_t;

  function automatic logic [WORD_W-1:0] pick_bit(input logic [FLAG_W-1:0] f);
    logic [WORD_W-1:0] w;
    w = f[WORD_W-1:0];
    if ((w & BIT_BRK_LO) != BIT_NONE) return BIT_BRK_LO;
    if ((w & BIT_BRK_HI) != BIT_NONE) return BIT_BRK_HI;
    if ((w & BIT_L3_LO) != BIT_NONE)  return BIT_L3_LO;
    if ((w & BIT_L3_HI) != BIT_NONE)  return BIT_L3_HI;
    if ((w & BIT_L2_LO) != BIT_NONE)  return BIT_L2_LO;
    if ((w & BIT_L2_HI) != BIT_NONE)  return BIT_L2_HI;
    if ((w & BIT_L1_LO) != BIT_NONE)  return BIT_L1_LO;
    if ((w & BIT_L1_HI) != BIT_NONE)  return BIT_L1_HI;
    return BIT_NONE;
  endfunction

  function automatic logic [WORD_W-1:0] level_code(input logic [WORD_W-1:0] w);
    if ((w & MASK_BRK) != BIT_NONE) return CODE_BRK;
    if ((w & MASK_L3) != BIT_NONE)  return CODE_L3;
    if ((w & MASK_L2) != BIT_NONE)  return CODE_L2;
    if ((w & MASK_L1) != BIT_NONE)  return CODE_L1;
    return CODE_NORM;
  endfunction

  function automatic logic [LVL_W-1:0] level_number(input logic [WORD_W-1:0] code);
    logic [LVL_W-1:0] n;
    case (code)
      CODE_BRK: n = SHOWN_BRK;
      CODE_L3:  n = SHOWN_L3;
      CODE_L2:  n = SHOWN_L2;
      CODE_L1:  n = SHOWN_L1;
      default:  n = SHOWN_NORM;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/aaup_ram.sv
// generic single-port-write, registered-read memory
`timescale 1ns / 1ps
module aaup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/aaup_update.sv
// display word and alarm time update for one point
`timescale 1ns / 1ps
module aaup_update (
  input  logic [aaup_pkg::WORD_W-1:0] rd_word,
  input  logic [aaup_pkg::TIME_W-1:0] rd_time,
  input  logic                        active,
  input  logic [aaup_pkg::FLAG_W-1:0] raw_flags,
  input  logic [aaup_pkg::TIME_W-1:0] event_time,
  input  logic [aaup_pkg::TIME_W-1:0] now_time,
  input  logic                        ack_pressed,
  input  logic                        reset_pressed,
  output aaup_pkg::aaup_upd_t         upd
);
  import aaup_pkg::*;

  logic [WORD_W-1:0] w;
  logic [WORD_W-1:0] bit_sel;
  logic [WORD_W-1:0] nl;
  logic [WORD_W-1:0] ol;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] keep;
  logic [WORD_W-1:0] prior_word;
  logic [TIME_W-1:0] t;

  always_comb begin
    w          = rd_word;
    t          = rd_time;
    bit_sel    = pick_bit(raw_flags);
    nl         = level_code(bit_sel);
    ol         = level_code(rd_word);
    lo         = nl - 12'd1;
    keep       = (nl != CODE_NORM) ? ((lo << 8) | lo) : BIT_NONE;
    prior_word = w;
    if (active) begin
      if (ack_pressed) begin
        w = w & CLR_FLASH;
      end else if (nl == ol) begin
        // change within the same level
        if ((bit_sel & w) == BIT_NONE && bit_sel != BIT_NONE) begin
          w = FLASH_BIT | bit_sel | (w & ~nl & ~(nl << 8));
          t = event_time;
        end
      end else if (nl > ol) begin
        w = FLASH_BIT | bit_sel | w;
        t = event_time;
      end else if ((w & FLASH_BIT) == BIT_NONE) begin
        // de-escalation
        if ((w & BIT_BRK_LO) != BIT_NONE) begin
          w = w & CLR_BRK_LO;
          t = now_time;
        end
        prior_word = w;
        if ((w & MASK_HELD) == BIT_NONE || reset_pressed) begin
          w = w & keep;
          if ((bit_sel & prior_word) != BIT_NONE) begin
            w = w | bit_sel;
          end else if (bit_sel != BIT_NONE) begin
            w = FLASH_BIT | w | bit_sel;
          end else begin
            w = BIT_NONE;
          end
          t = event_time;
        end
      end
    end
    upd.wr     = active;
    upd.word   = w;
    upd.tstamp = t;
  end

endmodule

// File: rtl/core/alarm_annunciator_point_update.sv
// alarm annunciator top level: point store, read-modify-write and result register
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+---------------------------------
//  request  | in_* fields                    | start high, busy low at the edge
//  result   | out_* fields                   | out_valid strobe, one cycle
//
// one request per cycle while busy is low; its out_valid strobe is registered through the
// request stage and then the result register, and comes with the result fields.
// the loop is the point store: read at accept, update and write back next cycle,
// with a one-entry forward for a request to the point written at the same edge.
// after reset busy stays high while the store is cleared.
// results cannot be held off by the receiver.
`timescale 1ns / 1ps
module alarm_annunciator_point_update #(
  parameter int NUM_POINTS = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [aaup_pkg::IDX_W-1:0]  in_point_index,
  input  logic                        in_point_in_use,
  input  logic                        in_point_masked,
  input  logic [aaup_pkg::FLAG_W-1:0] in_raw_flags,
  input  logic [aaup_pkg::TIME_W-1:0] in_event_time,
  input  logic [aaup_pkg::TIME_W-1:0] in_now_time,
  input  logic                        in_ack_pressed,
  input  logic                        in_reset_pressed,
  output logic                        out_valid,
  output logic [aaup_pkg::IDX_W-1:0]  out_result_index,
  output logic [aaup_pkg::WORD_W-1:0] out_display_word,
  output logic [aaup_pkg::TIME_W-1:0] out_display_time,
  output logic                        out_flashing,
  output logic [aaup_pkg::LVL_W-1:0]  out_shown_level
);
  import aaup_pkg::*;

  localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_POINTS - 1);

  aaup_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          accept;

  // request stage
  logic              s1_valid_r;
  logic              s1_inrange_r;
  logic [IDX_W-1:0]  s1_index_r;
  logic              s1_active_r;
  logic [FLAG_W-1:0] s1_flags_r;
  logic [TIME_W-1:0] s1_ev_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_ack_r;
  logic              s1_rst_r;

  // forward of the entry written at the accepting edge
  logic              fwd_hit_r;
  logic [WORD_W-1:0] fwd_word_r;
  logic [TIME_W-1:0] fwd_time_r;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [WORD_W-1:0] out_word_r;
  logic [TIME_W-1:0] out_time_r;
  logic [LVL_W-1:0]  out_level_r;

  logic [WORD_W-1:0] ram_word;
  logic [TIME_W-1:0] ram_time;
  logic [WORD_W-1:0] cur_word;
  logic [TIME_W-1:0] cur_time;
  aaup_upd_t         upd;
  logic              st_wr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_word;
  logic [TIME_W-1:0] wr_time;
  logic              fwd_hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    busy        = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt   = ST_RUN;
          clr_cnt_nxt = '0;
        end
      end
      ST_RUN: begin
        busy = 1'b0;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign accept = start && !busy;

  aaup_ram #(.WIDTH(WORD_W), .DEPTH(NUM_POINTS), .AW(AW)) u_word_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (AW'(in_point_index)),
    .rdata (ram_word)
  );

  aaup_ram #(.WIDTH(TIME_W), .DEPTH(NUM_POINTS), .AW(AW)) u_time_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_time),
    .raddr (AW'(in_point_index)),
    .rdata (ram_time)
  );

  assign cur_word = fwd_hit_r ? fwd_word_r : ram_word;
  assign cur_time = fwd_hit_r ? fwd_time_r : ram_time;

  aaup_update u_update (
    .rd_word       (cur_word),
    .rd_time       (cur_time),
    .active        (s1_active_r),
    .raw_flags     (s1_flags_r),
    .event_time    (s1_ev_r),
    .now_time      (s1_now_r),
    .ack_pressed   (s1_ack_r),
    .reset_pressed (s1_rst_r),
    .upd           (upd)
  );

  assign st_wr   = s1_valid_r && s1_inrange_r && upd.wr;
  assign wr_en   = (state_r == ST_CLEAR) || st_wr;
  assign wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : AW'(s1_index_r);
  assign wr_word = (state_r == ST_CLEAR) ? '0 : upd.word;
  assign wr_time = (state_r == ST_CLEAR) ? '0 : upd.tstamp;

  assign fwd_hit_nxt = accept && st_wr && (in_point_index == s1_index_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      fwd_hit_r   <= fwd_hit_nxt;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_index_r   <= in_point_index;
      s1_inrange_r <= 32'(in_point_index) < 32'(NUM_POINTS);
      s1_active_r  <= in_point_in_use && !in_point_masked;
      s1_flags_r   <= in_raw_flags;
      s1_ev_r      <= in_event_time;
      s1_now_r     <= in_now_time;
      s1_ack_r     <= in_ack_pressed;
      s1_rst_r     <= in_reset_pressed;
    end
    fwd_word_r <= upd.word;
    fwd_time_r <= upd.tstamp;
    if (s1_valid_r) begin
      out_index_r <= s1_index_r;
      if (s1_inrange_r) begin
        out_word_r  <= upd.word;
        out_time_r  <= upd.tstamp;
        out_level_r <= level_number(level_code(upd.word));
      end else begin
        out_word_r  <= '0;
        out_time_r  <= '0;
        out_level_r <= SHOWN_NORM;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_display_word = out_word_r;
  assign out_display_time = out_time_r;
  assign out_flashing     = out_word_r[4];
  assign out_shown_level  = out_level_r;

endmodule

// File: rtl/core/aaup_checker.sv
// port-level checks for the alarm annunciator, bound to the top level
`timescale 1ns / 1ps
module aaup_checker #(
  parameter int NUM_POINTS = 512
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [aaup_pkg::IDX_W-1:0]  in_point_index,
  input logic                        out_valid,
  input logic [aaup_pkg::IDX_W-1:0]  out_result_index,
  input logic [aaup_pkg::WORD_W-1:0] out_display_word,
  input logic                        out_flashing,
  input logic [aaup_pkg::LVL_W-1:0]  out_shown_level
);
  import aaup_pkg::*;

  // every request yields a result
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request without result");

  // no result without a request
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  a_res_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_index == $past(in_point_index, 2))
    else $error("result index mismatch");

  // a flashing point always shows an alarm level
  a_flash_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flashing) |-> out_shown_level != SHOWN_NORM)
    else $error("flashing with no alarm level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shown_level <= SHOWN_BRK &&
                   out_flashing == out_display_word[4] &&
                   (32'(out_result_index) < 32'(NUM_POINTS) ||
                    out_display_word == '0)))
    else $error("result fields inconsistent");

endmodule

bind alarm_annunciator_point_update aaup_checker #(.NUM_POINTS(NUM_POINTS)) u_aaup_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_point_index   (in_point_index),
  .out_valid        (out_valid),
  .out_result_index (out_result_index),
  .out_display_word (out_display_word),
  .out_flashing     (out_flashing),
  .out_shown_level  (out_shown_level)
);
